// ===== rtl/dcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dcr_pkg;

  // cache geometry and field widths
  localparam int CACHE_DEPTH    = 16;
  localparam int SLOT_W         = $clog2(CACHE_DEPTH);
  localparam int CNT_W          = SLOT_W + 1;
  localparam int ADDR_BITS      = 48;
  localparam int ALEN_W         = 5;
  localparam int REPLY_LEN_BITS = 16;
  localparam int PADDR_W        = 3;

  // request commands
  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_STORE  = 1'b1
  } cmd_t;

  // configuration register indexes (word address bit 2)
  typedef enum logic {
    REG_CACHE_ENABLE   = 1'b0,
    REG_ENTRIES_IN_USE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                      command;
    logic [31:0]               xid;
    logic [31:0]               prog;
    logic [31:0]               vers;
    logic [31:0]               proc;
    logic [ADDR_BITS-1:0]      peer_addr;
    logic [ALEN_W-1:0]         peer_addr_len;
    logic [REPLY_LEN_BITS-1:0] reply_len;
  } dcr_in_t;

  typedef struct packed {
    logic                      hit;
    logic [SLOT_W-1:0]         slot;
    logic [REPLY_LEN_BITS-1:0] cached_reply_len;
    logic                      stored;
  } dcr_out_t;

endpackage

`default_nettype wire

// ===== rtl/duplicate_request_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted transaction is registered in item_r, its result in out_r; out_valid flags it.
// Throughput: one transaction per cycle; busy stays low, the lookup compares all slots at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (rst_n low, synchronous): cache disabled, 16 slots in use, all slots invalid,
// victim pointer and recorded request key cleared.
module duplicate_request_cache (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire dcr_pkg::dcr_in_t            in_item,
  output logic                             out_valid,
  output dcr_pkg::dcr_out_t                out_result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dcr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import dcr_pkg::*;

  // configuration registers
  logic              cache_enable_r;
  logic [CNT_W-1:0]  entries_in_use_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  // input register
  logic              in_valid_r;
  dcr_in_t           item_r;

  // cache contents
  logic [CACHE_DEPTH-1:0]    valid_r;
  logic [CACHE_DEPTH-1:0]    newer_r [CACHE_DEPTH];
  logic [31:0]               entry_xid_r [CACHE_DEPTH];
  logic [31:0]               entry_prog_r [CACHE_DEPTH];
  logic [31:0]               entry_vers_r [CACHE_DEPTH];
  logic [31:0]               entry_proc_r [CACHE_DEPTH];
  logic [ADDR_BITS-1:0]      entry_addr_r [CACHE_DEPTH];
  logic [ALEN_W-1:0]         entry_addr_len_r [CACHE_DEPTH];
  logic [REPLY_LEN_BITS-1:0] entry_reply_len_r [CACHE_DEPTH];

  // recorded request key
  logic [SLOT_W-1:0]    victim_r;
  logic [31:0]          last_xid_r;
  logic [ADDR_BITS-1:0] last_addr_r;
  logic [ALEN_W-1:0]    last_addr_len_r;
  logic [31:0]          pending_prog_r;
  logic [31:0]          pending_vers_r;
  logic [31:0]          pending_proc_r;

  // result register
  logic     out_valid_r;
  dcr_out_t out_r;

  // lookup and store datapath
  logic [CACHE_DEPTH-1:0] match;
  logic [CACHE_DEPTH-1:0] best_sel;
  logic                   any_hit;
  logic [SLOT_W-1:0]      best_slot;
  logic [REPLY_LEN_BITS-1:0] best_len;
  logic [CNT_W-1:0]       slot_n;
  logic [SLOT_W-1:0]      wr_slot;
  logic [CNT_W-1:0]       wr_slot_inc;
  logic [SLOT_W-1:0]      victim_nxt;
  logic                   do_lookup;
  logic                   do_store;
  logic                   lookup_miss;
  dcr_out_t               out_nxt;

  // handshake outputs
  assign busy       = 1'b0;
  assign pready     = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // apb decode
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    case (cfg_idx)
      REG_CACHE_ENABLE:   prdata = {31'd0, cache_enable_r};
      REG_ENTRIES_IN_USE: prdata = {{(32-CNT_W){1'b0}}, entries_in_use_r};
      default:            prdata = 32'd0;
    endcase
  end

  // command decode
  assign do_lookup   = in_valid_r && (cmd_t'(item_r.command) == CMD_LOOKUP);
  assign do_store    = in_valid_r && (cmd_t'(item_r.command) == CMD_STORE) && cache_enable_r;
  assign lookup_miss = do_lookup && cache_enable_r && !any_hit;

  // parallel key compare across all slots
  always_comb begin
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      match[i] = valid_r[i] &&
                 (entry_xid_r[i] == item_r.xid) &&
                 (entry_prog_r[i] == item_r.prog) &&
                 (entry_vers_r[i] == item_r.vers) &&
                 (entry_proc_r[i] == item_r.proc) &&
                 (entry_addr_len_r[i] == item_r.peer_addr_len) &&
                 (entry_addr_r[i] == item_r.peer_addr);
    end
  end

  // newest match: no other matching slot was written after it
  always_comb begin
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      best_sel[i] = match[i] &&
                    ((match & ~newer_r[i] & ~(CACHE_DEPTH'(1) << i)) == '0);
    end
  end

  assign any_hit = |match;

  always_comb begin
    best_slot = '0;
    best_len  = '0;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      best_slot = best_slot | ({SLOT_W{best_sel[i]}} & SLOT_W'(i));
      best_len  = best_len | ({REPLY_LEN_BITS{best_sel[i]}} & entry_reply_len_r[i]);
    end
  end

  // victim slot with count clamped to 1..CACHE_DEPTH
  always_comb begin
    if (entries_in_use_r == '0) begin
      slot_n = CNT_W'(1);
    end else if (entries_in_use_r > CNT_W'(CACHE_DEPTH)) begin
      slot_n = CNT_W'(CACHE_DEPTH);
    end else begin
      slot_n = entries_in_use_r;
    end
    wr_slot     = ({1'b0, victim_r} >= slot_n) ? '0 : victim_r;
    wr_slot_inc = {1'b0, wr_slot} + CNT_W'(1);
    victim_nxt  = (wr_slot_inc >= slot_n) ? '0 : wr_slot_inc[SLOT_W-1:0];
  end

  // result fields
  always_comb begin
    out_nxt = '0;
    if (do_lookup && cache_enable_r && any_hit) begin
      out_nxt.hit              = 1'b1;
      out_nxt.slot             = best_slot;
      out_nxt.cached_reply_len = best_len;
    end else if (do_store) begin
      out_nxt.stored = 1'b1;
      out_nxt.slot   = wr_slot;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_enable_r   <= 1'b0;
      entries_in_use_r <= CNT_W'(CACHE_DEPTH);
      in_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      valid_r          <= '0;
      victim_r         <= '0;
      last_xid_r       <= '0;
      last_addr_r      <= '0;
      last_addr_len_r  <= '0;
      pending_prog_r   <= '0;
      pending_vers_r   <= '0;
      pending_proc_r   <= '0;
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        newer_r[i] <= '0;
      end
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
      // configuration writes; enabling empties the cache
      if (cfg_wr) begin
        case (cfg_idx)
          REG_CACHE_ENABLE: begin
            if (pwdata[0] && !cache_enable_r) begin
              valid_r  <= '0;
              victim_r <= '0;
            end
            cache_enable_r <= pwdata[0];
          end
          REG_ENTRIES_IN_USE: entries_in_use_r <= pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
      // lookup always records id and address, miss records the rest
      if (do_lookup) begin
        last_xid_r      <= item_r.xid;
        last_addr_r     <= item_r.peer_addr;
        last_addr_len_r <= item_r.peer_addr_len;
      end
      if (lookup_miss) begin
        pending_prog_r <= item_r.prog;
        pending_vers_r <= item_r.vers;
        pending_proc_r <= item_r.proc;
      end
      // store marks slot valid and newest of all
      if (do_store) begin
        valid_r[wr_slot] <= 1'b1;
        victim_r         <= victim_nxt;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
          if (SLOT_W'(i) == wr_slot) begin
            newer_r[i] <= ~(CACHE_DEPTH'(1) << i);
          end else begin
            newer_r[i][wr_slot] <= 1'b0;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= in_item;
    end
    out_r <= out_nxt;
    if (do_store) begin
      entry_xid_r[wr_slot]       <= last_xid_r;
      entry_prog_r[wr_slot]      <= pending_prog_r;
      entry_vers_r[wr_slot]      <= pending_vers_r;
      entry_proc_r[wr_slot]      <= pending_proc_r;
      entry_addr_r[wr_slot]      <= last_addr_r;
      entry_addr_len_r[wr_slot]  <= last_addr_len_r;
      entry_reply_len_r[wr_slot] <= item_r.reply_len;
    end
  end

  // a registered transaction produces its result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |=> out_valid_r)
    else $error("registered transaction produced no result");

  // hit and stored never reported together
  a_hit_xor_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.hit && out_r.stored))
    else $error("result flags both hit and stored");

  // a hit selects exactly one newest slot
  a_single_newest: assert property (@(posedge clk) disable iff (!rst_n)
    (do_lookup && any_hit) |-> $onehot(best_sel))
    else $error("newest-match select is not one-hot");

  // stored slot lies inside the slot count in use
  a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    do_store |-> ({1'b0, wr_slot} < slot_n))
    else $error("store slot beyond entry count");

endmodule

`default_nettype wire

// ===== tb/sv/duplicate_request_cache_test.sv =====
`timescale 1ns / 1ps

module duplicate_request_cache_test;
  import dcr_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 4;

  // request key as the cache compares it
  typedef struct packed {
    logic [31:0]          xid;
    logic [31:0]          prog;
    logic [31:0]          vers;
    logic [31:0]          proc;
    logic [ADDR_BITS-1:0] addr;
    logic [ALEN_W-1:0]    alen;
  } req_key_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start;
  logic              busy;
  dcr_in_t           in_item;
  logic              out_valid;
  dcr_out_t          out_result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  duplicate_request_cache u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // predicted cache contents and configuration
  bit                        cache_on;
  logic [4:0]                entries_cfg;
  bit                        slot_valid [CACHE_DEPTH];
  req_key_t                  slot_key [CACHE_DEPTH];
  logic [REPLY_LEN_BITS-1:0] slot_reply_len [CACHE_DEPTH];
  int unsigned               slot_age [CACHE_DEPTH];
  int unsigned               store_serial;
  int                        victim_slot;
  logic [31:0]               rec_xid;
  logic [ADDR_BITS-1:0]      rec_addr;
  logic [ALEN_W-1:0]         rec_alen;
  logic [31:0]               pend_prog;
  logic [31:0]               pend_vers;
  logic [31:0]               pend_proc;

  dcr_out_t   expected_results [$];
  dcr_out_t   want;
  req_key_t   key_pool [$];
  int         error_count = 0;
  int         idle_cycles = 0;
  bit         gaps_on = 1'b1;

  function automatic void empty_cache();
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      slot_valid[i] = 1'b0;
      slot_age[i] = 0;
    end
    store_serial = 0;
    victim_slot = 0;
  endfunction

  function automatic void reset_prediction();
    cache_on = 1'b0;
    entries_cfg = 5'd16;
    empty_cache();
    rec_xid = '0;
    rec_addr = '0;
    rec_alen = '0;
    pend_prog = '0;
    pend_vers = '0;
    pend_proc = '0;
  endfunction

  function automatic void apply_reg_write(reg_idx_t idx, logic [31:0] value);
    if (idx == REG_CACHE_ENABLE) begin
      // turning the cache on flushes it
      if (value[0] && !cache_on)
        empty_cache();
      cache_on = value[0];
    end else begin
      entries_cfg = value[4:0];
    end
  endfunction

  // expected result of one transaction, updating the predicted state
  function automatic dcr_out_t predict_cache_result(dcr_in_t it);
    dcr_out_t r;
    bit       found;
    int       best;
    int       n;
    int       v;
    r = '0;
    if (it.command == CMD_LOOKUP) begin
      rec_xid = it.xid;
      rec_addr = it.peer_addr;
      rec_alen = it.peer_addr_len;
      if (cache_on) begin
        found = 1'b0;
        best = 0;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
          if (slot_valid[i] && slot_key[i].xid == it.xid && slot_key[i].prog == it.prog &&
              slot_key[i].vers == it.vers && slot_key[i].proc == it.proc &&
              slot_key[i].alen == it.peer_addr_len && slot_key[i].addr == it.peer_addr) begin
            if (!found || slot_age[i] > slot_age[best])
              best = i;
            found = 1'b1;
          end
        end
        if (found) begin
          r.hit = 1'b1;
          r.slot = SLOT_W'(best);
          r.cached_reply_len = slot_reply_len[best];
        end else begin
          pend_prog = it.prog;
          pend_vers = it.vers;
          pend_proc = it.proc;
        end
      end
    end else if (cache_on) begin
      n = (entries_cfg == 0) ? 1 : (entries_cfg > CACHE_DEPTH) ? CACHE_DEPTH : int'(entries_cfg);
      v = (victim_slot >= n) ? 0 : victim_slot;
      slot_valid[v] = 1'b1;
      slot_key[v] = '{xid: rec_xid, prog: pend_prog, vers: pend_vers, proc: pend_proc,
                      addr: rec_addr, alen: rec_alen};
      slot_reply_len[v] = it.reply_len;
      store_serial++;
      slot_age[v] = store_serial;
      victim_slot = (v + 1 >= n) ? 0 : v + 1;
      r.stored = 1'b1;
      r.slot = SLOT_W'(v);
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: %p", out_result);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_result.hit !== want.hit) begin
          $error("hit: expected %0h, actual %0h", want.hit, out_result.hit);
          error_count++;
        end
        if (out_result.slot !== want.slot) begin
          $error("slot: expected %0h, actual %0h", want.slot, out_result.slot);
          error_count++;
        end
        if (out_result.cached_reply_len !== want.cached_reply_len) begin
          $error("cached_reply_len: expected %0h, actual %0h", want.cached_reply_len,
                 out_result.cached_reply_len);
          error_count++;
        end
        if (out_result.stored !== want.stored) begin
          $error("stored: expected %0h, actual %0h", want.stored, out_result.stored);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction of any kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // send one transaction; entered and left at a falling edge
  task automatic send_item(dcr_in_t item);
    while (gaps_on && $urandom_range(0, 99) < 37) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_cache_result(item));
    @(negedge clk);
  endtask

  // hold off until every result is in, then let the pipeline empty
  task automatic settle();
    start <= 1'b0;
    while (expected_results.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // register write: setup then access phase, then psel drops and the bus idles before return
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg_write(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  function automatic req_key_t rand_key();
    req_key_t k;
    k.xid = $urandom;
    k.prog = $urandom;
    k.vers = $urandom;
    k.proc = $urandom;
    k.addr = ADDR_BITS'({$urandom, $urandom});
    k.alen = ALEN_W'($urandom_range(0, 28));
    return k;
  endfunction

  task automatic send_lookup(req_key_t k);
    dcr_in_t it;
    it.command = CMD_LOOKUP;
    it.xid = k.xid;
    it.prog = k.prog;
    it.vers = k.vers;
    it.proc = k.proc;
    it.peer_addr = k.addr;
    it.peer_addr_len = k.alen;
    it.reply_len = REPLY_LEN_BITS'($urandom);
    send_item(it);
  endtask

  // store: key fields carry junk that the cache must ignore
  task automatic send_store(logic [REPLY_LEN_BITS-1:0] len);
    dcr_in_t  it;
    req_key_t junk;
    junk = rand_key();
    it.command = CMD_STORE;
    it.xid = junk.xid;
    it.prog = junk.prog;
    it.vers = junk.vers;
    it.proc = junk.proc;
    it.peer_addr = junk.addr;
    it.peer_addr_len = ALEN_W'($urandom);
    it.reply_len = len;
    send_item(it);
  endtask

  function automatic void remember_key(req_key_t k);
    key_pool.push_back(k);
    if (key_pool.size() > 32)
      void'(key_pool.pop_front());
  endfunction

  // ---------------- directed tests ----------------

  task automatic test_store_before_lookup();
    write_reg(REG_CACHE_ENABLE, 32'h1);
    // recorded key still at its reset value
    send_store(16'hFFFF);
    send_lookup('0);
    settle();
  endtask

  task automatic test_field_extremes();
    req_key_t k;
    k = '1;
    k.alen = 5'd28;
    send_lookup(k);
    send_store(16'h0000);
    send_lookup(k);
    // unused address lengths above the range
    k.alen = 5'd31;
    send_lookup(k);
    send_store(16'h8001);
    settle();
  endtask

  task automatic test_hit_keeps_request_key();
    req_key_t ka;
    req_key_t kb;
    ka = rand_key();
    kb = '1;
    kb.alen = 5'd28;
    send_lookup(ka);
    // hit records id and address only
    send_lookup(kb);
    send_store(16'h1234);
    kb.prog = ka.prog;
    kb.vers = ka.vers;
    kb.proc = ka.proc;
    send_lookup(kb);
    settle();
  endtask

  task automatic test_newest_match(output req_key_t kc);
    kc = rand_key();
    send_lookup(kc);
    send_store(16'h0001);
    send_lookup(kc);
    send_store(16'h0002);
    // two slots hold the key, the later store wins
    send_lookup(kc);
    settle();
  endtask

  task automatic test_cache_disable(req_key_t kc);
    write_reg(REG_CACHE_ENABLE, 32'h0);
    send_lookup(kc);
    send_store(16'h0003);
    settle();
    // re-enable flushes every slot
    write_reg(REG_CACHE_ENABLE, 32'hFFFF_FFFF);
    send_lookup(kc);
    send_store(16'h0004);
    settle();
    // enable while already on keeps contents
    write_reg(REG_CACHE_ENABLE, 32'h1);
    send_lookup(kc);
    settle();
  endtask

  task automatic test_entry_count(req_key_t kc);
    write_reg(REG_ENTRIES_IN_USE, 32'd16);
    repeat (3) send_store(REPLY_LEN_BITS'($urandom));
    settle();
    // victim pointer now past the count
    write_reg(REG_ENTRIES_IN_USE, 32'd2);
    send_store(16'h00AA);
    send_store(16'h00BB);
    send_lookup(kc);
    settle();
    write_reg(REG_ENTRIES_IN_USE, 32'd0);
    send_store(16'h00CC);
    settle();
    write_reg(REG_ENTRIES_IN_USE, 32'hFFFF_FFFF);
    send_store(16'h00DD);
    settle();
  endtask

  // ---------------- random traffic ----------------

  task automatic run_phase(int phase, int items);
    int       sent;
    int       pick;
    bit       paused;
    req_key_t k;
    sent = 0;
    paused = 1'b0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // request then reply
        if (key_pool.size() != 0 && $urandom_range(0, 3) == 0)
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
          k = rand_key();
        remember_key(k);
        send_lookup(k);
        send_store(REPLY_LEN_BITS'($urandom));
        sent += 2;
      end else if (pick < 70) begin
        // retransmission, sometimes off by one bit
        if (key_pool.size() != 0)
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
          k = rand_key();
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 5))
            0: k.xid ^= 32'(1) << $urandom_range(0, 31);
            1: k.prog ^= 32'(1) << $urandom_range(0, 31);
            2: k.vers ^= 32'(1) << $urandom_range(0, 31);
            3: k.proc ^= 32'(1) << $urandom_range(0, 31);
            4: k.addr ^= ADDR_BITS'(1) << $urandom_range(0, ADDR_BITS - 1);
            default: k.alen ^= ALEN_W'(1) << $urandom_range(0, ALEN_W - 1);
          endcase
        end
        send_lookup(k);
        sent++;
      end else if (pick < 85) begin
        send_store(REPLY_LEN_BITS'($urandom));
        sent++;
      end else begin
        k = rand_key();
        k.alen = ALEN_W'($urandom_range(0, 31));
        send_lookup(k);
        sent++;
      end
      // in phase 2, once halfway, the sender holds off until the cache has answered everything
      if (phase == 2 && !paused && sent >= items / 2) begin
        paused = 1'b1;
        settle();
      end
    end
    settle();
  endtask

  task automatic test_random_traffic();
    int phase_entries [10] = '{16, 1, 4, 0, 31, 7, 16, 2, 12, 16};
    bit phase_enable [10] = '{1, 1, 1, 1, 0, 1, 1, 1, 1, 1};
    for (int p = 0; p < 10; p++) begin
      write_reg(REG_ENTRIES_IN_USE, ($urandom & ~32'h1F) | 32'(phase_entries[p]));
      write_reg(REG_CACHE_ENABLE, ($urandom & ~32'h1) | 32'(phase_enable[p]));
      gaps_on = (p != 7);
      run_phase(p, 95);
    end
    gaps_on = 1'b1;
  endtask

  // main sequence
  initial begin
    req_key_t kc;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    reset_prediction();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_store_before_lookup();
    test_field_extremes();
    test_hit_keeps_request_key();
    test_newest_match(kc);
    test_cache_disable(kc);
    test_entry_count(kc);
    test_random_traffic();

    settle();
    if (expected_results.size() != 0) begin
      $error("%0d result transactions never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
